### rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Holds the port payload structs and the work struct passed between stages.
// No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int IN_W      = 16;
    localparam int MAG_W     = 15;
    localparam int SUM_W     = IN_W + 3;
    localparam int POS_W     = SUM_W - 2;
    localparam int ROOT_W    = 16;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 1;
    localparam int STEPS     = 2;
    localparam int NSTAGE    = ROOT_W / STEPS;
    localparam int NLANE     = 4;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m22;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m01;
    } t_in;

    typedef struct packed {
        logic        [MAG_W-1:0] q_scalar;
        logic signed [IN_W-1:0]  q_x;
        logic signed [IN_W-1:0]  q_y;
        logic signed [IN_W-1:0]  q_z;
    } t_out;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_lane;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sgn;

    // lane 0 is w, lanes 1..3 are x, y, z; sgn[0..2] belong to x, y, z
    typedef struct packed {
        t_lane [NLANE-1:0]   lane;
        t_sgn  [NLANE-2:0]   sgn;
    } t_work;

endpackage

### rtl/rmq_front.sv
// Input stage: forms the four clamped diagonal sums and the sign flags.
// Depends on rmq_pkg.
module rmq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rmq_pkg::t_in        i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rmq_pkg::t_work      o_work
);

    logic           r_valid;
    rmq_pkg::t_work r_work;
    rmq_pkg::t_work n_work;

    logic signed [rmq_pkg::SUM_W-1:0] w_one;
    logic signed [rmq_pkg::SUM_W-1:0] w_a;
    logic signed [rmq_pkg::SUM_W-1:0] w_b;
    logic signed [rmq_pkg::SUM_W-1:0] w_c;
    logic signed [rmq_pkg::SUM_W-1:0] w_sum [rmq_pkg::NLANE];

    function automatic rmq_pkg::t_lane seed(input logic signed [rmq_pkg::SUM_W-1:0] s);
        rmq_pkg::t_lane             l;
        logic [rmq_pkg::POS_W-1:0]  p;
        p = (!s[rmq_pkg::SUM_W-1] && (s != '0)) ? s[rmq_pkg::POS_W-1:0] : '0;
        l.rad  = rmq_pkg::RAD_W'(p) << (rmq_pkg::FRAC_BITS - 2);
        l.root = '0;
        l.rem  = '0;
        return l;
    endfunction

    assign w_one = rmq_pkg::SUM_W'(rmq_pkg::ONE);
    assign w_a   = rmq_pkg::SUM_W'(i_data.m00);
    assign w_b   = rmq_pkg::SUM_W'(i_data.m11);
    assign w_c   = rmq_pkg::SUM_W'(i_data.m22);

    assign w_sum[0] = w_one + w_a + w_b + w_c;
    assign w_sum[1] = w_one + w_a - w_b - w_c;
    assign w_sum[2] = w_one - w_a + w_b - w_c;
    assign w_sum[3] = w_one - w_a - w_b + w_c;

    always_comb begin
        for (int i = 0; i < rmq_pkg::NLANE; i++) begin
            n_work.lane[i] = seed(w_sum[i]);
        end
        n_work.sgn[0].neg  = i_data.m21 < i_data.m12;
        n_work.sgn[0].zero = i_data.m21 == i_data.m12;
        n_work.sgn[1].neg  = i_data.m02 < i_data.m20;
        n_work.sgn[1].zero = i_data.m02 == i_data.m20;
        n_work.sgn[2].neg  = i_data.m10 < i_data.m01;
        n_work.sgn[2].zero = i_data.m10 == i_data.m01;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

### rtl/rmq_sqrt_stage.sv
// One stage of the digit-by-digit square root: two root bits for all lanes.
// Depends on rmq_pkg.
module rmq_sqrt_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rmq_pkg::t_work      i_work,
    output logic                o_valid,
    input  logic                i_ready,
    output rmq_pkg::t_work      o_work
);

    logic           r_valid;
    rmq_pkg::t_work r_work;
    rmq_pkg::t_work n_work;

    function automatic rmq_pkg::t_lane sq_step(input rmq_pkg::t_lane l);
        rmq_pkg::t_lane              o;
        logic [rmq_pkg::REM_W+1:0]   cur;
        logic [rmq_pkg::REM_W+1:0]   trial;
        cur   = {l.rem, l.rad[rmq_pkg::RAD_W-1 -: 2]};
        trial = (rmq_pkg::REM_W + 2)'({l.root, 2'b01});
        o.rad = l.rad << 2;
        if (cur >= trial) begin
            o.rem  = rmq_pkg::REM_W'(cur - trial);
            o.root = {l.root[rmq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rmq_pkg::REM_W'(cur);
            o.root = {l.root[rmq_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_work = i_work;
        for (int i = 0; i < rmq_pkg::NLANE; i++) begin
            for (int s = 0; s < rmq_pkg::STEPS; s++) begin
                n_work.lane[i] = sq_step(n_work.lane[i]);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

### rtl/rmq_back.sv
// Output stage: saturates the roots to one, applies signs, registers the beat.
// Depends on rmq_pkg.
module rmq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rmq_pkg::t_work      i_work,
    output logic                o_valid,
    input  logic                i_ready,
    output rmq_pkg::t_out       o_data
);

    logic          r_valid;
    rmq_pkg::t_out r_data;
    rmq_pkg::t_out n_data;
    logic [rmq_pkg::MAG_W-1:0] w_mag [rmq_pkg::NLANE];
    logic signed [rmq_pkg::IN_W-1:0] w_vec [rmq_pkg::NLANE-1];

    always_comb begin
        for (int i = 0; i < rmq_pkg::NLANE; i++) begin
            if (i_work.lane[i].root > rmq_pkg::ROOT_W'(rmq_pkg::ONE)) begin
                w_mag[i] = rmq_pkg::MAG_W'(rmq_pkg::ONE);
            end else begin
                w_mag[i] = i_work.lane[i].root[rmq_pkg::MAG_W-1:0];
            end
        end
        for (int i = 0; i < rmq_pkg::NLANE - 1; i++) begin
            if (i_work.sgn[i].zero) begin
                w_vec[i] = '0;
            end else if (i_work.sgn[i].neg) begin
                w_vec[i] = -$signed(rmq_pkg::IN_W'(w_mag[i+1]));
            end else begin
                w_vec[i] = $signed(rmq_pkg::IN_W'(w_mag[i+1]));
            end
        end
        n_data.q_scalar = w_mag[0];
        n_data.q_x      = w_vec[0];
        n_data.q_y      = w_vec[1];
        n_data.q_z      = w_vec[2];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion, top level.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_stage, rmq_back.
//
// Usage: one 3x3 matrix (nine signed Q1.14 elements) enters per input beat
// on i_in_valid/o_in_ready with payload i_in_data; one quaternion leaves per
// output beat on o_out_valid/i_out_ready with payload o_out_data.
// The front stage forms the diagonal sums and sign flags, the square root
// stages run two root bits per stage for all four components in parallel,
// and the back stage saturates, signs and registers the beat.
// Throughput is one beat per cycle while i_out_ready stays high; every
// stage holds its own valid bit, so bubbles collapse and an input beat is
// taken while a result waits. When i_out_ready is low the output holds,
// stages fill up behind it, and o_in_ready drops only once every stage is
// occupied. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the block keeps no state between matrices.
module rotation_matrix_to_quaternion_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rmq_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rmq_pkg::t_out  o_out_data
);

    logic           w_valid [rmq_pkg::NSTAGE+1];
    logic           w_ready [rmq_pkg::NSTAGE+1];
    rmq_pkg::t_work w_work  [rmq_pkg::NSTAGE+1];

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_work  (w_work[0])
    );

    for (genvar k = 0; k < rmq_pkg::NSTAGE; k++) begin : g_sqrt
        rmq_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_work  (w_work[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_work  (w_work[k+1])
        );
    end

    rmq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[rmq_pkg::NSTAGE]),
        .o_ready (w_ready[rmq_pkg::NSTAGE]),
        .i_work  (w_work[rmq_pkg::NSTAGE]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

### rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, with bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_top.
module rmq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input rmq_pkg::t_in   i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input rmq_pkg::t_out  o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed under stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_scalar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.q_scalar <= rmq_pkg::ONE)
        else $error("scalar part above one");

    a_vec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.q_x >= -rmq_pkg::ONE) && (o_out_data.q_x <= rmq_pkg::ONE)
            && (o_out_data.q_y >= -rmq_pkg::ONE) && (o_out_data.q_y <= rmq_pkg::ONE)
            && (o_out_data.q_z >= -rmq_pkg::ONE) && (o_out_data.q_z <= rmq_pkg::ONE))
        else $error("vector part out of range");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
